FILE: design/mcofl_pkg.sv
// Shared types and constants for the maze cell offset block.
`timescale 1ns / 1ps

package mcofl_pkg;

    localparam int PIX_W      = 10;
    localparam int PLEN_W     = 11;
    localparam int CFG_W      = 11;
    localparam int OFFSET_X_W = 8;
    localparam int OFFSET_Z_W = 9;
    localparam int REM_W      = 8;

    localparam int HALF_TURN    = 180;
    localparam int QUARTER_TURN = 90;

    localparam logic [CFG_W-1:0] MIN_PIXEL_LENGTH_RST = 11'd20;
    localparam logic [CFG_W-1:0] LENGTH_BIAS_RST      = 11'd320;

    typedef enum logic [0:0] {
        REG_MIN_PIXEL_LENGTH = 1'b0,
        REG_LENGTH_BIAS      = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic                         qualify;
        logic                         horiz;
        logic                         vert;
        logic                         head;
        logic                         head_vert;
        logic                         last;
        logic signed [OFFSET_X_W-1:0] x_off;
        logic [OFFSET_Z_W-1:0]        z_off;
    } line_info_t;

    typedef struct packed {
        logic                         z_valid;
        logic                         x_valid;
        logic [OFFSET_Z_W-1:0]        offset_z;
        logic signed [OFFSET_X_W-1:0] offset_x;
    } result_t;

endpackage

FILE: design/maze_cell_offset_from_lines_core.sv
// Top level: maze cell offset from detected lines, stream ports and register file.
//
// Channel   Dir  Handshake              Content
// s_        in   s_tvalid / s_tready    one detected line, s_tlast ends the frame
// m_        out  m_tvalid / m_tready    cell offsets, one transaction per frame
// cfg_      in   cfg_valid / cfg_ready  register write: index and data
//
// Takes one line per cycle while s_tready is high; a four-stage front pipeline
// (multiply by the reciprocal of 180 sets its depth) feeds a two-entry queue;
// m_tvalid is set when the back unit pops a frame's last line. Reset is synchronous
// on aresetn low and loads the register defaults. A stalled m_ side blocks only
// the next frame's last line in the back unit; the queue and then s_tready absorb it.
`timescale 1ns / 1ps

module maze_cell_offset_from_lines_core #(
    parameter int COORD_WIDTH = 16,
    localparam int S_TDATA_W  = ((4 * COORD_WIDTH + 40 + 7) / 8) * 8,
    localparam int M_TDATA_W  = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // wx_start, end_wx, wz_start, end_wz, start_px, end_px, start_py, end_py
    input  logic [S_TDATA_W-1:0]            s_tdata,
    // line_oob, is_heading
    input  logic [1:0]                      s_tuser,
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // offset_x, offset_z
    output logic [M_TDATA_W-1:0]            m_tdata,
    // x_valid, z_valid
    output logic [1:0]                      m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  mcofl_pkg::reg_index_t           cfg_index,
    input  logic [mcofl_pkg::CFG_W-1:0]     cfg_data
);

    localparam int CW      = COORD_WIDTH;
    localparam int PW      = mcofl_pkg::PIX_W;
    localparam int SCORE_W = ((CW > 11) ? CW : 11) + 3;
    localparam int INFO_W  = $bits(mcofl_pkg::line_info_t);
    localparam int Q_W     = SCORE_W + INFO_W;
    localparam int RES_BITS = mcofl_pkg::OFFSET_X_W + mcofl_pkg::OFFSET_Z_W;

    logic [mcofl_pkg::CFG_W-1:0] min_pixel_length_reg, length_bias_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_pixel_length_reg <= mcofl_pkg::MIN_PIXEL_LENGTH_RST;
            length_bias_reg      <= mcofl_pkg::LENGTH_BIAS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mcofl_pkg::REG_MIN_PIXEL_LENGTH: min_pixel_length_reg <= cfg_data;
                mcofl_pkg::REG_LENGTH_BIAS:      length_bias_reg      <= cfg_data;
            endcase
        end
    end

    logic                       push, q_full, q_valid, pop;
    logic signed [SCORE_W-1:0]  push_score;
    mcofl_pkg::line_info_t      push_info;
    logic [Q_W-1:0]             q_data;
    mcofl_pkg::result_t         res;

    mcofl_front #(
        .COORD_WIDTH (CW),
        .SCORE_W     (SCORE_W)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .wx_start         (s_tdata[0*CW +: CW]),
        .end_wx           (s_tdata[1*CW +: CW]),
        .wz_start         (s_tdata[2*CW +: CW]),
        .end_wz           (s_tdata[3*CW +: CW]),
        .start_px         (s_tdata[4*CW +: PW]),
        .end_px           (s_tdata[4*CW + PW +: PW]),
        .start_py         (s_tdata[4*CW + 2*PW +: PW]),
        .end_py           (s_tdata[4*CW + 3*PW +: PW]),
        .line_oob         (s_tuser[0]),
        .is_heading       (s_tuser[1]),
        .last_line        (s_tlast),
        .min_pixel_length (min_pixel_length_reg),
        .length_bias      (length_bias_reg),
        .q_full           (q_full),
        .push             (push),
        .push_score       (push_score),
        .push_info        (push_info)
    );

    mcofl_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_score, push_info}),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .head_data (q_data)
    );

    mcofl_back #(
        .SCORE_W (SCORE_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_score   (q_data[Q_W-1 -: SCORE_W]),
        .q_info    (q_data[INFO_W-1:0]),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {(M_TDATA_W - RES_BITS)'(0), res.offset_z, res.offset_x};
    assign m_tuser = {res.z_valid, res.x_valid};

endmodule

FILE: design/mcofl_front.sv
// Front pipeline: line measurement, scoring and cell offset of each line.
`timescale 1ns / 1ps

module mcofl_front #(
    parameter int COORD_WIDTH = 16,
    parameter int SCORE_W     = 19
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [COORD_WIDTH-1:0]          wx_start,
    input  logic signed [COORD_WIDTH-1:0]          end_wx,
    input  logic signed [COORD_WIDTH-1:0]          wz_start,
    input  logic signed [COORD_WIDTH-1:0]          end_wz,
    input  logic [mcofl_pkg::PIX_W-1:0]            start_px,
    input  logic [mcofl_pkg::PIX_W-1:0]            end_px,
    input  logic [mcofl_pkg::PIX_W-1:0]            start_py,
    input  logic [mcofl_pkg::PIX_W-1:0]            end_py,
    input  logic                                   line_oob,
    input  logic                                   is_heading,
    input  logic                                   last_line,
    input  logic [mcofl_pkg::CFG_W-1:0]            min_pixel_length,
    input  logic [mcofl_pkg::CFG_W-1:0]            length_bias,
    input  logic                                   q_full,
    output logic                                   push,
    output logic signed [SCORE_W-1:0]              push_score,
    output mcofl_pkg::line_info_t                  push_info
);

    localparam int CW      = COORD_WIDTH;
    localparam int QW      = CW - 7;
    localparam int SHIFT   = CW + 8;
    localparam longint unsigned RECIP_L = (64'd1 << SHIFT) / 64'd180;
    localparam logic [CW:0] RECIP       = RECIP_L[CW:0];
    localparam logic [CW:0] HALF_W      = (CW + 1)'(mcofl_pkg::HALF_TURN);
    localparam logic [8:0]  HALF_9      = 9'(mcofl_pkg::HALF_TURN);
    localparam logic signed [8:0] QUARTER_9 = 9'(mcofl_pkg::QUARTER_TURN);

    function automatic logic [CW-1:0] abs_c(input logic [CW-1:0] v);
        abs_c = v[CW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [CW:0] abs_w(input logic [CW:0] v);
        abs_w = v[CW] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [mcofl_pkg::PIX_W-1:0] abs_p(input logic [mcofl_pkg::PIX_W:0] v);
        logic [mcofl_pkg::PIX_W:0] a;
        a = v[mcofl_pkg::PIX_W] ? (~v + 1'b1) : v;
        abs_p = a[mcofl_pkg::PIX_W-1:0];
    endfunction

    logic adv;

    // stage 1
    logic                              v1_reg;
    logic [CW-1:0]                     a_swx_reg, a_ewx_reg, a_swz_reg, a_ewz_reg;
    logic [CW-1:0]                     dx1_reg, dz1_reg, mx1_reg, mz1_reg;
    logic                              nx1_reg, nz1_reg;
    logic [mcofl_pkg::PLEN_W-1:0]      plen_reg;
    logic                              oob1_reg, head1_reg, last1_reg;

    // stage 2
    logic                              v2_reg;
    logic signed [SCORE_W-1:0]         score2_reg;
    logic                              qual2_reg, horiz2_reg, vert2_reg, hvert2_reg;
    logic                              head2_reg, last2_reg;
    logic [CW-1:0]                     mx2_reg, mz2_reg;
    logic                              nx2_reg, nz2_reg;
    logic [QW-1:0]                     qx2_reg, qz2_reg;

    // stage 3
    logic                              v3_reg;
    logic signed [SCORE_W-1:0]         score3_reg;
    logic                              qual3_reg, horiz3_reg, vert3_reg, hvert3_reg;
    logic                              head3_reg, last3_reg;
    logic [mcofl_pkg::REM_W-1:0]       rx3_reg, rz3_reg;
    logic                              nx3_reg, nz3_reg;

    // stage 4
    logic                              v4_reg;
    logic signed [SCORE_W-1:0]         score4_reg;
    mcofl_pkg::line_info_t             info4_reg;

    // stage 1 logic
    logic [CW:0] dxs, dzs, xsum, zsum, xsum_a, zsum_a;
    logic [CW:0] dx_a, dz_a;

    assign dxs    = {end_wx[CW-1], end_wx} - {wx_start[CW-1], wx_start};
    assign dzs    = {end_wz[CW-1], end_wz} - {wz_start[CW-1], wz_start};
    assign xsum   = {wx_start[CW-1], wx_start} + {end_wx[CW-1], end_wx};
    assign zsum   = {wz_start[CW-1], wz_start} + {end_wz[CW-1], end_wz};
    assign dx_a   = abs_w(dxs);
    assign dz_a   = abs_w(dzs);
    assign xsum_a = abs_w(xsum);
    assign zsum_a = abs_w(zsum);

    logic [mcofl_pkg::PLEN_W-1:0] plen_c;
    assign plen_c = mcofl_pkg::PLEN_W'(abs_p({1'b0, end_px} - {1'b0, start_px}))
                  + mcofl_pkg::PLEN_W'(abs_p({1'b0, start_py} - {1'b0, end_py}));

    // stage 2 logic
    logic signed [SCORE_W-1:0] score_c;
    logic [2*CW+1:0]           prod_x, prod_z;

    assign score_c = SCORE_W'(length_bias) - SCORE_W'(plen_reg)
                   + SCORE_W'(a_swx_reg) + SCORE_W'(a_ewx_reg)
                   + SCORE_W'(a_swz_reg) + SCORE_W'(a_ewz_reg);
    assign prod_x  = (2*CW+2)'(mx1_reg) * (2*CW+2)'(RECIP);
    assign prod_z  = (2*CW+2)'(mz1_reg) * (2*CW+2)'(RECIP);

    // stage 3 logic
    logic [CW:0] tx, tz;
    logic [8:0]  rx9, rz9;
    logic [mcofl_pkg::REM_W-1:0] rx_c, rz_c;

    assign tx   = {1'b0, mx2_reg} - (CW + 1)'((CW + 1)'(qx2_reg) * HALF_W);
    assign tz   = {1'b0, mz2_reg} - (CW + 1)'((CW + 1)'(qz2_reg) * HALF_W);
    assign rx9  = tx[8:0];
    assign rz9  = tz[8:0];
    assign rx_c = (rx9 >= HALF_9) ? mcofl_pkg::REM_W'(rx9 - HALF_9) : rx9[7:0];
    assign rz_c = (rz9 >= HALF_9) ? mcofl_pkg::REM_W'(rz9 - HALF_9) : rz9[7:0];

    // stage 4 logic
    logic signed [8:0] xo9;
    logic [8:0]        zo9;

    assign xo9 = (nx3_reg && (rx3_reg != '0)) ? ($signed({1'b0, rx3_reg}) - QUARTER_9)
                                              : (QUARTER_9 - $signed({1'b0, rx3_reg}));
    assign zo9 = nz3_reg ? (HALF_9 + 9'(rz3_reg)) : (HALF_9 - 9'(rz3_reg));

    assign adv        = !v4_reg || !q_full;
    assign in_ready   = adv;
    assign push       = v4_reg && !q_full;
    assign push_score = score4_reg;
    assign push_info  = info4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_swx_reg <= abs_c(wx_start);
            a_ewx_reg <= abs_c(end_wx);
            a_swz_reg <= abs_c(wz_start);
            a_ewz_reg <= abs_c(end_wz);
            dx1_reg   <= dx_a[CW-1:0];
            dz1_reg   <= dz_a[CW-1:0];
            mx1_reg   <= xsum_a[CW:1];
            mz1_reg   <= zsum_a[CW:1];
            nx1_reg   <= xsum[CW];
            nz1_reg   <= zsum[CW];
            plen_reg  <= plen_c;
            oob1_reg  <= line_oob;
            head1_reg <= is_heading;
            last1_reg <= last_line;

            score2_reg <= score_c;
            qual2_reg  <= !oob1_reg && (plen_reg > min_pixel_length);
            horiz2_reg <= dx1_reg > dz1_reg;
            vert2_reg  <= dz1_reg > dx1_reg;
            hvert2_reg <= dz1_reg >= dx1_reg;
            head2_reg  <= head1_reg;
            last2_reg  <= last1_reg;
            mx2_reg    <= mx1_reg;
            mz2_reg    <= mz1_reg;
            nx2_reg    <= nx1_reg;
            nz2_reg    <= nz1_reg;
            qx2_reg    <= prod_x[SHIFT +: QW];
            qz2_reg    <= prod_z[SHIFT +: QW];

            score3_reg <= score2_reg;
            qual3_reg  <= qual2_reg;
            horiz3_reg <= horiz2_reg;
            vert3_reg  <= vert2_reg;
            hvert3_reg <= hvert2_reg;
            head3_reg  <= head2_reg;
            last3_reg  <= last2_reg;
            rx3_reg    <= rx_c;
            rz3_reg    <= rz_c;
            nx3_reg    <= nx2_reg;
            nz3_reg    <= nz2_reg;

            score4_reg          <= score3_reg;
            info4_reg.qualify   <= qual3_reg;
            info4_reg.horiz     <= horiz3_reg;
            info4_reg.vert      <= vert3_reg;
            info4_reg.head      <= head3_reg;
            info4_reg.head_vert <= hvert3_reg;
            info4_reg.last      <= last3_reg;
            info4_reg.x_off     <= xo9[7:0];
            info4_reg.z_off     <= zo9;
        end
    end

endmodule

FILE: design/mcofl_queue.sv
// Two-entry queue between the front pipeline and the back unit.
`timescale 1ns / 1ps

module mcofl_queue #(
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic              not_empty,
    output logic [DATA_W-1:0] head_data
);

    logic [DATA_W-1:0] mem_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/mcofl_back.sv
// Back unit: best-line tracking, heading capture and frame result register.
`timescale 1ns / 1ps

module mcofl_back #(
    parameter int SCORE_W = 19
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      q_valid,
    input  logic signed [SCORE_W-1:0] q_score,
    input  mcofl_pkg::line_info_t     q_info,
    output logic                      pop,
    output logic                      res_valid,
    input  logic                      res_ready,
    output mcofl_pkg::result_t        res
);

    logic                                    h_found_reg, v_found_reg;
    logic                                    head_seen_reg, head_vert_reg;
    logic signed [SCORE_W-1:0]               best_h_score_reg, best_v_score_reg;
    logic [mcofl_pkg::OFFSET_Z_W-1:0]        best_h_zoff_reg, head_zoff_reg;
    logic signed [mcofl_pkg::OFFSET_X_W-1:0] best_v_xoff_reg, head_xoff_reg;
    logic                                    res_valid_reg;
    mcofl_pkg::result_t                      res_reg;

    logic                                    take_h, take_v, out_free;
    logic                                    h_found_next, v_found_next;
    logic                                    head_seen_next, head_vert_next;
    logic [mcofl_pkg::OFFSET_Z_W-1:0]        best_h_zoff_next, head_zoff_next;
    logic signed [mcofl_pkg::OFFSET_X_W-1:0] best_v_xoff_next, head_xoff_next;
    mcofl_pkg::result_t                      res_next;

    assign out_free = !res_valid_reg || res_ready;
    assign pop      = q_valid && (!q_info.last || out_free);

    assign take_h = q_info.qualify && q_info.horiz && (!h_found_reg || q_score < best_h_score_reg);
    assign take_v = q_info.qualify && q_info.vert && (!v_found_reg || q_score < best_v_score_reg);

    assign h_found_next     = h_found_reg || take_h;
    assign v_found_next     = v_found_reg || take_v;
    assign best_h_zoff_next = take_h ? q_info.z_off : best_h_zoff_reg;
    assign best_v_xoff_next = take_v ? q_info.x_off : best_v_xoff_reg;
    assign head_seen_next   = head_seen_reg || q_info.head;
    assign head_vert_next   = q_info.head ? q_info.head_vert : head_vert_reg;
    assign head_xoff_next   = q_info.head ? q_info.x_off : head_xoff_reg;
    assign head_zoff_next   = q_info.head ? q_info.z_off : head_zoff_reg;

    always_comb begin
        res_next = '0;
        if (head_seen_next) begin
            if (head_vert_next) begin
                res_next.offset_x = head_xoff_next;
                res_next.x_valid  = 1'b1;
                if (h_found_next) begin
                    res_next.offset_z = best_h_zoff_next;
                    res_next.z_valid  = 1'b1;
                end
            end else begin
                res_next.offset_z = head_zoff_next;
                res_next.z_valid  = 1'b1;
                if (v_found_next) begin
                    res_next.offset_x = best_v_xoff_next;
                    res_next.x_valid  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_found_reg   <= 1'b0;
            v_found_reg   <= 1'b0;
            head_seen_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (pop && q_info.last) begin
                h_found_reg   <= 1'b0;
                v_found_reg   <= 1'b0;
                head_seen_reg <= 1'b0;
                res_valid_reg <= 1'b1;
            end else begin
                if (pop) begin
                    h_found_reg   <= h_found_next;
                    v_found_reg   <= v_found_next;
                    head_seen_reg <= head_seen_next;
                end
                if (res_ready) begin
                    res_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            if (take_h) begin
                best_h_score_reg <= q_score;
            end
            if (take_v) begin
                best_v_score_reg <= q_score;
            end
            best_h_zoff_reg <= best_h_zoff_next;
            best_v_xoff_reg <= best_v_xoff_next;
            head_vert_reg   <= head_vert_next;
            head_xoff_reg   <= head_xoff_next;
            head_zoff_reg   <= head_zoff_next;
            if (q_info.last) begin
                res_reg <= res_next;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule
